@@ rtl/tofl_pkg.sv @@
// Shared types, codes and widths of the tag ownership and flush tracker.
package tofl_pkg;

  localparam int TAG_W = 16;
  localparam int CPU_W = 16;
  localparam int CMD_W = 3;
  localparam int STATUS_W = 3;
  localparam int IN_DATA_W = 56;
  localparam int OUT_DATA_W = 40;
  localparam int CPU_LIMIT_DEFAULT = 256;
  localparam int ROW_BITS = 64;
  localparam int BIT_IDX_W = 6;

  localparam logic [CMD_W-1:0] CMD_ACQUIRE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 3'd2;
  localparam logic [CMD_W-1:0] CMD_COMPLETE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
  localparam logic [STATUS_W-1:0] ST_STALE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ALLOCFAIL = 3'd4;
  localparam logic [STATUS_W-1:0] ST_PROTO = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [TAG_W-1:0] guest_tag;
    logic [TAG_W-1:0] alloc_tag;
    logic             alloc_ok;
    logic [CPU_W-1:0] cpu_index;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                flush_needed;
    logic                give_back_valid;
    logic [TAG_W-1:0]    give_back_tag;
    logic                is_active;
    logic                flush_pending;
    logic [TAG_W-1:0]    host_tag;
  } result_t;

  typedef struct packed {
    logic             active;
    logic [TAG_W-1:0] guest_tag;
    logic [TAG_W-1:0] host_tag;
    logic             pending;
  } owner_t;

  typedef struct packed {
    logic set;
    logic clear;
  } bm_ctrl_t;

endpackage

@@ rtl/tofl_bitmap.sv @@
// Per-CPU residency bitmap held as 64-bit rows with a valid bit for each row.
module tofl_bitmap #(
  parameter int CPU_LIMIT = tofl_pkg::CPU_LIMIT_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [tofl_pkg::CPU_W-1:0] cpu_index,
  input  tofl_pkg::bm_ctrl_t        ctrl,
  output logic                      resident,
  output logic                      empty
);
  import tofl_pkg::*;

  localparam int WORDS = (CPU_LIMIT + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_W = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [ROW_BITS-1:0] rows [WORDS];
  logic [WORDS-1:0]    row_valid;
  logic [ROW_W-1:0]    row;
  logic [BIT_IDX_W-1:0] bit_idx;
  logic                row_ok;
  logic [ROW_BITS-1:0] row_data;

  assign row = cpu_index[BIT_IDX_W +: ROW_W];
  assign bit_idx = cpu_index[BIT_IDX_W-1:0];
  assign row_ok = (ROW_W+1)'(row) < (ROW_W+1)'(WORDS);

  always_comb begin
    row_data = '0;
    if (row_ok && row_valid[row]) begin
      row_data = rows[row];
    end
  end

  assign resident = row_data[bit_idx];
  assign empty = ~|row_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (ctrl.clear) begin
      row_valid <= '0;
    end else if (ctrl.set && row_ok) begin
      row_valid[row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.set && !ctrl.clear && row_ok) begin
      rows[row] <= row_data | (ROW_BITS'(1) << bit_idx);
    end
  end

endmodule

@@ rtl/tofl_eval.sv @@
// Command evaluation: consistency check, result fields and next owner state.
module tofl_eval #(
  parameter int CPU_LIMIT = tofl_pkg::CPU_LIMIT_DEFAULT
) (
  input  tofl_pkg::item_t    item,
  input  tofl_pkg::owner_t   owner,
  input  logic               resident,
  input  logic               empty,
  output tofl_pkg::owner_t   owner_next,
  output tofl_pkg::bm_ctrl_t bm_ctrl,
  output tofl_pkg::result_t  result
);
  import tofl_pkg::*;

  logic consistent;
  logic cpu_ok;

  assign cpu_ok = 17'(item.cpu_index) < 17'(CPU_LIMIT);

  always_comb begin
    if (owner.active) begin
      consistent = (owner.guest_tag != '0) && (owner.host_tag != '0) &&
                   (owner.guest_tag != owner.host_tag) && !(owner.pending && !empty);
    end else begin
      consistent = (owner.guest_tag == '0) && (owner.host_tag == '0) && empty;
    end
  end

  always_comb begin
    owner_next = owner;
    bm_ctrl = '0;
    result = '0;
    result.status = ST_OK;
    case (item.cmd)
      CMD_ACQUIRE: begin
        if (item.guest_tag == '0) begin
          result.status = ST_INVALID;
        end else if (!consistent) begin
          result.status = ST_PROTO;
        end else if (owner.active) begin
          result.status = (owner.guest_tag == item.guest_tag) ? ST_OK : ST_STALE;
        end else if (!item.alloc_ok) begin
          result.status = ST_ALLOCFAIL;
        end else if (item.alloc_tag == '0 || item.alloc_tag == item.guest_tag) begin
          result.status = ST_NOSPACE;
          if (item.alloc_tag != '0) begin
            result.give_back_valid = 1'b1;
            result.give_back_tag = item.alloc_tag;
          end
        end else begin
          owner_next.active = 1'b1;
          owner_next.guest_tag = item.guest_tag;
          owner_next.host_tag = item.alloc_tag;
          owner_next.pending = 1'b1;
          bm_ctrl.clear = 1'b1;
        end
      end
      CMD_FLUSH: begin
        if (!consistent) begin
          result.status = ST_PROTO;
        end else begin
          owner_next.pending = 1'b1;
          bm_ctrl.clear = 1'b1;
        end
      end
      CMD_QUERY, CMD_COMPLETE: begin
        if (!cpu_ok) begin
          result.status = ST_INVALID;
        end else if (!consistent) begin
          result.status = ST_PROTO;
        end else if (!owner.active) begin
          result.status = ST_INVALID;
        end else if (item.cmd == CMD_QUERY) begin
          result.flush_needed = owner.pending || !resident;
        end else begin
          owner_next.pending = 1'b0;
          bm_ctrl.set = 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (!consistent) begin
          result.status = ST_PROTO;
        end else begin
          if (owner.active) begin
            result.give_back_valid = 1'b1;
            result.give_back_tag = owner.host_tag;
          end
          owner_next = '0;
          bm_ctrl.clear = 1'b1;
        end
      end
      default: begin
        result.status = ST_INVALID;
      end
    endcase
    result.is_active = owner_next.active;
    result.flush_pending = owner_next.pending;
    result.host_tag = owner_next.active ? owner_next.host_tag : '0;
  end

endmodule

@@ rtl/tag_ownership_flush_tracker.sv @@
// Top level of the tag ownership and flush tracker: input register, owner state, result register.
//
//   Channel | Direction | Handshake          | Contents
//   s       | in        | s_tvalid, s_tready | command item in s_tdata
//   m       | out       | m_tvalid, m_tready | result item in m_tdata
//
// An accepted item waits in the input register and is offered as a result once it moves into the free result register.
// One item is accepted per cycle unless a stall on m holds the input register full: the input
// register empties into the result register whenever that register is empty or being taken.
// Owner state and the residency bitmap change as an item moves into the result register.
// Synchronous active-high reset empties both registers and clears all ownership state.
// A stall on m holds the result and, once the input register is full, lowers s_tready.
module tag_ownership_flush_tracker #(
  parameter int CPU_LIMIT = tofl_pkg::CPU_LIMIT_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // cmd[2:0], guest_tag[18:3], alloc_tag[34:19], alloc_ok[35], cpu_index[51:36], zeros above
  input  logic [tofl_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // status[2:0], flush_needed[3], give_back_valid[4], give_back_tag[20:5], is_active[21],
  // flush_pending[22], host_tag[38:23], zeros above
  output logic [tofl_pkg::OUT_DATA_W-1:0] m_tdata
);
  import tofl_pkg::*;

  item_t    in_item;
  item_t    item;
  logic     item_valid;
  logic     advance;
  owner_t   owner;
  owner_t   owner_next;
  bm_ctrl_t bm_ctrl;
  logic     resident;
  logic     empty;
  result_t  result_next;
  result_t  result;

  assign in_item.cmd = s_tdata[2:0];
  assign in_item.guest_tag = s_tdata[18:3];
  assign in_item.alloc_tag = s_tdata[34:19];
  assign in_item.alloc_ok = s_tdata[35];
  assign in_item.cpu_index = s_tdata[51:36];

  assign advance = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= in_item;
    end
  end

  tofl_bitmap #(
    .CPU_LIMIT(CPU_LIMIT)
  ) u_bitmap (
    .clk(clk),
    .rst(rst),
    .cpu_index(item.cpu_index),
    .ctrl(advance ? bm_ctrl : '0),
    .resident(resident),
    .empty(empty)
  );

  tofl_eval #(
    .CPU_LIMIT(CPU_LIMIT)
  ) u_eval (
    .item(item),
    .owner(owner),
    .resident(resident),
    .empty(empty),
    .owner_next(owner_next),
    .bm_ctrl(bm_ctrl),
    .result(result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      owner <= '0;
    end else if (advance) begin
      owner <= owner_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign m_tdata = {1'b0, result.host_tag, result.flush_pending, result.is_active,
                    result.give_back_tag, result.give_back_valid, result.flush_needed,
                    result.status};

  a_no_proto_error: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> result.status != ST_PROTO)
    else $error("owner state became inconsistent");

  a_host_tag_follows_active: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (result.is_active == (result.host_tag != '0)))
    else $error("host tag does not agree with the active mark");

  a_give_back_tag_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !result.give_back_valid) |-> result.give_back_tag == '0)
    else $error("give-back tag set without a give-back");

  a_accept_fills_register: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> item_valid)
    else $error("accepted item lost from the input register");

  a_residency_needs_owner: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (owner.active && !owner.pending))
    else $error("residency recorded without an active owner");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the tag ownership and flush tracker, with a built-in predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tofl_pkg::*;

  localparam int CPU_LIMIT = CPU_LIMIT_DEFAULT;
  localparam int CPU_IDX_W = $clog2(CPU_LIMIT);
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int grants = 0;
  int resident_hits = 0;

  logic                 own_active = 1'b0;
  logic [TAG_W-1:0]     own_guest = '0;
  logic [TAG_W-1:0]     own_host = '0;
  logic                 own_pending = 1'b0;
  logic [CPU_LIMIT-1:0] cpu_resident = '0;

  result_t owner_results_due[$];

  tag_ownership_flush_tracker #(
    .CPU_LIMIT(CPU_LIMIT)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles without draining.", cycle_count);
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic owner_state_sane();
    if (!own_active) begin
      return own_guest == '0 && own_host == '0 && cpu_resident == '0;
    end
    return !(own_guest == '0 || own_host == '0 || own_guest == own_host ||
             (own_pending && cpu_resident != '0));
  endfunction

  function automatic result_t track_owner_event(input item_t it);
    result_t r;
    logic sane;
    r = '0;
    r.status = ST_OK;
    sane = owner_state_sane();
    case (it.cmd)
      CMD_ACQUIRE: begin
        if (it.guest_tag == '0) begin
          r.status = ST_INVALID;
        end else if (!sane) begin
          r.status = ST_PROTO;
        end else if (own_active) begin
          r.status = (own_guest == it.guest_tag) ? ST_OK : ST_STALE;
        end else if (!it.alloc_ok) begin
          r.status = ST_ALLOCFAIL;
        end else if (it.alloc_tag == '0 || it.alloc_tag == it.guest_tag) begin
          r.status = ST_NOSPACE;
          if (it.alloc_tag != '0) begin
            r.give_back_valid = 1'b1;
            r.give_back_tag = it.alloc_tag;
          end
        end else begin
          own_active = 1'b1;
          own_guest = it.guest_tag;
          own_host = it.alloc_tag;
          own_pending = 1'b1;
          cpu_resident = '0;
          grants++;
        end
      end
      CMD_FLUSH: begin
        if (!sane) begin
          r.status = ST_PROTO;
        end else begin
          cpu_resident = '0;
          own_pending = 1'b1;
        end
      end
      CMD_QUERY, CMD_COMPLETE: begin
        if (it.cpu_index >= CPU_LIMIT) begin
          r.status = ST_INVALID;
        end else if (!sane) begin
          r.status = ST_PROTO;
        end else if (!own_active) begin
          r.status = ST_INVALID;
        end else if (it.cmd == CMD_QUERY) begin
          r.flush_needed = own_pending || !cpu_resident[it.cpu_index[CPU_IDX_W-1:0]];
          if (!r.flush_needed) resident_hits++;
        end else begin
          cpu_resident[it.cpu_index[CPU_IDX_W-1:0]] = 1'b1;
          own_pending = 1'b0;
        end
      end
      CMD_RELEASE: begin
        if (!sane) begin
          r.status = ST_PROTO;
        end else begin
          if (own_active) begin
            r.give_back_valid = 1'b1;
            r.give_back_tag = own_host;
          end
          own_active = 1'b0;
          own_guest = '0;
          own_host = '0;
          own_pending = 1'b0;
          cpu_resident = '0;
        end
      end
      default: begin
        r.status = ST_INVALID;
      end
    endcase
    r.is_active = own_active;
    r.flush_pending = own_pending;
    r.host_tag = own_active ? own_host : '0;
    return r;
  endfunction

  task automatic send_item(input item_t it);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_DATA_W-52){1'b0}}, it.cpu_index, it.alloc_ok, it.alloc_tag,
                it.guest_tag, it.cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    owner_results_due.push_back(track_owner_event(it));
    items_sent++;
  endtask

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [TAG_W-1:0] gt,
                          input logic [TAG_W-1:0] at, input logic ok,
                          input logic [CPU_W-1:0] cpu);
    item_t it;
    it.cmd = cmd;
    it.guest_tag = gt;
    it.alloc_tag = at;
    it.alloc_ok = ok;
    it.cpu_index = cpu;
    send_item(it);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (owner_results_due.size() == 0) begin
        $error("Result item arrived with none outstanding: 0x%0h", m_tdata);
        error_count++;
      end else begin
        want = owner_results_due.pop_front();
        check_field("status", 32'(want.status), 32'(m_tdata[2:0]));
        check_field("flush_needed", 32'(want.flush_needed), 32'(m_tdata[3]));
        check_field("give_back_valid", 32'(want.give_back_valid), 32'(m_tdata[4]));
        check_field("give_back_tag", 32'(want.give_back_tag), 32'(m_tdata[20:5]));
        check_field("is_active", 32'(want.is_active), 32'(m_tdata[21]));
        check_field("flush_pending", 32'(want.flush_pending), 32'(m_tdata[22]));
        check_field("host_tag", 32'(want.host_tag), 32'(m_tdata[38:23]));
        check_field("padding", 0, 32'(m_tdata[OUT_DATA_W-1:39]));
        results_checked++;
      end
    end
  end

  task automatic test_inactive_commands();
    send_cmd(CMD_QUERY, 16'h0000, 16'h0000, 1'b0, 16'd0);
    send_cmd(CMD_COMPLETE, 16'h0000, 16'h0000, 1'b0, 16'd300);
    send_cmd(CMD_RELEASE, 16'h0000, 16'h0000, 1'b0, 16'd0);
    send_cmd(CMD_FLUSH, 16'h0000, 16'h0000, 1'b0, 16'd0);
    send_cmd(CMD_COMPLETE, 16'h0000, 16'h0000, 1'b1, 16'd5);
    send_cmd(CMD_RELEASE, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF);
  endtask

  task automatic test_acquire_paths();
    send_cmd(CMD_ACQUIRE, 16'h0000, 16'h0042, 1'b1, 16'd0);
    send_cmd(CMD_ACQUIRE, 16'h1234, 16'h0042, 1'b0, 16'd0);
    send_cmd(CMD_ACQUIRE, 16'h1234, 16'h0000, 1'b1, 16'd0);
    send_cmd(CMD_ACQUIRE, 16'h1234, 16'h1234, 1'b1, 16'd0);
    send_cmd(CMD_ACQUIRE, 16'hFFFF, 16'h0001, 1'b1, 16'd0);
    send_cmd(CMD_ACQUIRE, 16'hFFFF, 16'h0000, 1'b0, 16'd0);
    send_cmd(CMD_ACQUIRE, 16'h1234, 16'h5678, 1'b1, 16'd0);
  endtask

  task automatic test_flush_and_residency();
    send_cmd(CMD_QUERY, 16'h0000, 16'h0000, 1'b0, CPU_W'(CPU_LIMIT - 1));
    send_cmd(CMD_COMPLETE, 16'h0000, 16'h0000, 1'b0, CPU_W'(CPU_LIMIT - 1));
    send_cmd(CMD_QUERY, 16'h0000, 16'h0000, 1'b0, CPU_W'(CPU_LIMIT - 1));
    send_cmd(CMD_QUERY, 16'h0000, 16'h0000, 1'b0, 16'd0);
    send_cmd(CMD_QUERY, 16'h0000, 16'h0000, 1'b0, CPU_W'(CPU_LIMIT));
    send_cmd(CMD_COMPLETE, 16'h0000, 16'h0000, 1'b0, 16'hFFFF);
    send_cmd(CMD_FLUSH, 16'h0000, 16'h0000, 1'b0, 16'd0);
    send_cmd(CMD_QUERY, 16'h0000, 16'h0000, 1'b0, CPU_W'(CPU_LIMIT - 1));
  endtask

  task automatic test_spare_codes_and_release();
    for (int c = 32'(CMD_SPARE_LO); c <= 32'(CMD_SPARE_HI); c++) begin
      send_cmd(c[CMD_W-1:0], 16'hFFFF, 16'hFFFF, 1'b1, 16'd1);
    end
    send_cmd(CMD_RELEASE, 16'h0000, 16'h0000, 1'b0, 16'd0);
    send_cmd(CMD_ACQUIRE, 16'h8001, 16'hFFFF, 1'b1, 16'd0);
    send_cmd(CMD_RELEASE, 16'h0000, 16'h0000, 1'b0, 16'd0);
  endtask

  task automatic test_random_traffic(input int count);
    item_t it;
    int    pick;
    for (int n = 0; n < count; n++) begin
      it.guest_tag = TAG_W'($urandom);
      it.alloc_tag = TAG_W'($urandom);
      it.alloc_ok = ($urandom_range(9) != 0);
      it.cpu_index = CPU_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 20) begin
        it.cmd = CMD_ACQUIRE;
        pick = $urandom_range(9);
        if (own_active && pick < 5) it.guest_tag = own_guest;
        else if (pick == 5) it.guest_tag = '0;
        pick = $urandom_range(9);
        if (pick == 0) it.alloc_tag = '0;
        else if (pick == 1) it.alloc_tag = it.guest_tag;
      end else if (pick < 28) begin
        it.cmd = CMD_FLUSH;
      end else if (pick < 83) begin
        it.cmd = (pick < 58) ? CMD_QUERY : CMD_COMPLETE;
        pick = $urandom_range(9);
        if (pick < 7) it.cpu_index = CPU_W'($urandom_range(7));
        else if (pick < 9) it.cpu_index = CPU_W'($urandom_range(CPU_LIMIT - 1));
      end else if (pick < 93) begin
        it.cmd = CMD_RELEASE;
      end else if (pick < 96) begin
        it.cmd = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
      end else begin
        it.cmd = CMD_W'($urandom_range(CMD_SPARE_HI));
      end
      send_item(it);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 16;
    recv_idle_pct = 66;
    test_inactive_commands();
    test_acquire_paths();
    test_flush_and_residency();
    test_spare_codes_and_release();
    test_random_traffic(360);

    send_idle_pct = 66;
    recv_idle_pct = 16;
    test_random_traffic(360);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(360);

    s_tvalid <= 1'b0;
    while (owner_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items and checked %0d results under three idling mixes.",
             items_sent, results_checked);
    $display("Covered %0d tag grants and %0d queries that found a CPU resident.",
             grants, resident_hits);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
